// ===== rtl/core/source_code_tokenizer_defines.svh =====
// assertion macros for the source code tokenizer
// used by the top level only; no other dependencies
`ifndef SOURCE_CODE_TOKENIZER_DEFINES_SVH
`define SOURCE_CODE_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication
`define SCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`else

`define SCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SCT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/sct_pkg.sv =====
// shared constants, types and the punctuation lookup for the tokenizer
// no dependencies
`timescale 1ns / 1ps

package sct_pkg;

    localparam int POSITION_BITS_DEFAULT = 24;
    localparam int KIND_BITS   = 5;
    localparam int STATUS_BITS = 2;
    localparam int VALUE_BITS  = 64;

    // result queue between scanner and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QLEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

    // token kinds
    localparam logic [KIND_BITS-1:0] KIND_WORD   = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_INT    = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_LBRACK = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_RBRACK = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_DOT    = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_MINUS  = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_DMINUS = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_PLUS   = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_DPLUS  = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_STAR   = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_SLASH  = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_COMMA  = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_SEMI   = 5'd16;
    localparam logic [KIND_BITS-1:0] KIND_COLON  = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_AMP    = 5'd18;
    localparam logic [KIND_BITS-1:0] KIND_BAR    = 5'd19;
    localparam logic [KIND_BITS-1:0] KIND_CARET  = 5'd20;
    localparam logic [KIND_BITS-1:0] KIND_TILDE  = 5'd21;
    localparam logic [KIND_BITS-1:0] KIND_BANG   = 5'd22;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN = 5'd23;
    localparam logic [KIND_BITS-1:0] KIND_DEQ    = 5'd24;
    localparam logic [KIND_BITS-1:0] KIND_END    = 5'd25;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_BYTE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNCLOSED = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN  = 2'd3;

    // characters
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7a;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5a;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_FIRST_HIGH = 8'd128;

    typedef struct packed {
        logic [1:0] count;   // results written this cycle, 0 to 2
    } push_t;

    typedef struct packed {
        logic                   room;       // at least two free entries
        logic                   nonempty;
        logic [QLEVEL_BITS-1:0] level;
    } q_status_t;

    // kind of a single-character token, KIND_WORD when the byte is none
    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] b);
        logic [KIND_BITS-1:0] k;
        case (b)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7b:   k = KIND_LBRACE;
            8'h7d:   k = KIND_RBRACE;
            8'h5b:   k = KIND_LBRACK;
            8'h5d:   k = KIND_RBRACK;
            8'h2e:   k = KIND_DOT;
            8'h2a:   k = KIND_STAR;
            8'h2c:   k = KIND_COMMA;
            8'h3b:   k = KIND_SEMI;
            8'h3a:   k = KIND_COLON;
            8'h26:   k = KIND_AMP;
            8'h7c:   k = KIND_BAR;
            8'h5e:   k = KIND_CARET;
            8'h7e:   k = KIND_TILDE;
            8'h21:   k = KIND_BANG;
            default: k = KIND_WORD;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/sct_front.sv =====
// scanner: accepts source bytes, tracks the pending token and writes
// up to two results per item into the result queue; uses sct_pkg
`timescale 1ns / 1ps

module sct_front #(
    parameter int POS_BITS = sct_pkg::POSITION_BITS_DEFAULT,
    parameter int RES_BITS = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    source_valid,
    input  logic [7:0]              source_byte,
    input  logic                    end_of_input,
    input  sct_pkg::q_status_t      q_stat,
    output sct_pkg::push_t          push,
    output logic [RES_BITS-1:0]     wr0,
    output logic [RES_BITS-1:0]     wr1
);

    localparam int VB = sct_pkg::VALUE_BITS;

    typedef enum logic [3:0] {
        M_IDLE,
        M_WORD,
        M_NUM,
        M_MINUS,
        M_PLUS,
        M_EQ,
        M_SLASH,
        M_COMMENT,
        M_CSTAR
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] pstart_reg, pstart_next;
    logic [POS_BITS-1:0] plen_reg, plen_next;
    logic [VB-1:0]       acc_reg, acc_next;
    logic                err_reg, err_next;

    logic                accept;
    logic                is_alpha, is_digit, is_ws, is_bad, pend_mode, brk;
    logic [VB-1:0]       acc_times_ten;
    logic [POS_BITS-1:0] plen_grown;

    // held token (first result) and second result
    logic                      a_v, b_v;
    logic [sct_pkg::KIND_BITS-1:0] f_kind, b_kind, s_kind;
    logic [POS_BITS-1:0]       f_len, b_len, b_start;
    logic [VB-1:0]             f_value;
    logic [sct_pkg::STATUS_BITS-1:0] b_status;
    logic [RES_BITS-2:0]       body_a, body_b;

    assign accept = source_valid && q_stat.room;

    assign is_alpha = (source_byte inside {[sct_pkg::CH_LOW_A:sct_pkg::CH_LOW_Z],
                                           [sct_pkg::CH_UP_A:sct_pkg::CH_UP_Z]});
    assign is_digit = (source_byte inside {[sct_pkg::CH_ZERO:sct_pkg::CH_NINE]});
    assign is_ws    = (source_byte == sct_pkg::CH_SPACE) ||
                      (source_byte == sct_pkg::CH_NEWLINE);
    assign is_bad   = ((source_byte < sct_pkg::CH_SPACE) && !is_ws) ||
                      (source_byte >= sct_pkg::CH_FIRST_HIGH);
    assign pend_mode = (mode_reg inside {M_WORD, M_NUM, M_MINUS, M_PLUS, M_EQ, M_SLASH});
    assign s_kind   = sct_pkg::single_kind(source_byte);

    // times ten as two shifted copies
    assign acc_times_ten = {acc_reg[VB-4:0], 3'b000} + {acc_reg[VB-2:0], 1'b0};
    assign plen_grown    = (&plen_reg) ? plen_reg : plen_reg + 1'b1;

    // what the held token looks like if it is flushed now
    always_comb
    begin
        f_kind  = sct_pkg::KIND_END;
        f_len   = POS_BITS'(1);
        f_value = '0;
        case (mode_reg)
            M_WORD:
            begin
                f_kind = sct_pkg::KIND_WORD;
                f_len  = plen_reg;
            end
            M_NUM:
            begin
                f_kind  = sct_pkg::KIND_INT;
                f_len   = plen_reg;
                f_value = acc_reg;
            end
            M_MINUS: f_kind = sct_pkg::KIND_MINUS;
            M_PLUS:  f_kind = sct_pkg::KIND_PLUS;
            M_EQ:    f_kind = sct_pkg::KIND_ASSIGN;
            M_SLASH: f_kind = sct_pkg::KIND_SLASH;
            default: f_kind = sct_pkg::KIND_END;
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        acc_next    = acc_reg;
        err_next    = err_reg;
        a_v         = 1'b0;
        b_v         = 1'b0;
        brk         = 1'b0;
        b_kind      = sct_pkg::KIND_END;
        b_status    = sct_pkg::ST_OK;
        b_start     = pos_reg;
        b_len       = '0;

        if (accept && !err_reg)
        begin
            if (end_of_input)
            begin
                if (mode_reg inside {M_COMMENT, M_CSTAR})
                begin
                    b_v      = 1'b1;
                    b_status = sct_pkg::ST_UNCLOSED;
                    err_next = 1'b1;
                end
                else
                begin
                    a_v         = pend_mode;
                    b_v         = 1'b1;
                    mode_next   = M_IDLE;
                    pstart_next = '0;
                    plen_next   = '0;
                    acc_next    = '0;
                    pos_next    = '0;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (is_bad)
                begin
                    mode_next   = M_IDLE;
                    pstart_next = '0;
                    plen_next   = '0;
                    acc_next    = '0;
                    b_v         = 1'b1;
                    b_status    = sct_pkg::ST_BAD_BYTE;
                    err_next    = 1'b1;
                end
                else
                begin
                    case (mode_reg)
                        M_COMMENT:
                        begin
                            if (source_byte == sct_pkg::CH_STAR)
                                mode_next = M_CSTAR;
                        end
                        M_CSTAR:
                        begin
                            if (source_byte == sct_pkg::CH_SLASH)
                                mode_next = M_IDLE;
                            else if (source_byte != sct_pkg::CH_STAR)
                                mode_next = M_COMMENT;
                        end
                        M_WORD:
                        begin
                            if (is_alpha || is_digit)
                                plen_next = plen_grown;
                            else
                                brk = 1'b1;
                        end
                        M_NUM:
                        begin
                            if (is_digit)
                            begin
                                acc_next  = acc_times_ten +
                                            VB'(source_byte - sct_pkg::CH_ZERO);
                                plen_next = plen_grown;
                            end
                            else
                                brk = 1'b1;
                        end
                        M_MINUS, M_PLUS, M_EQ:
                        begin
                            if ((mode_reg == M_MINUS && source_byte == sct_pkg::CH_MINUS) ||
                                (mode_reg == M_PLUS && source_byte == sct_pkg::CH_PLUS) ||
                                (mode_reg == M_EQ && source_byte == sct_pkg::CH_EQUAL))
                            begin
                                b_v     = 1'b1;
                                b_kind  = (mode_reg == M_MINUS) ? sct_pkg::KIND_DMINUS :
                                          (mode_reg == M_PLUS)  ? sct_pkg::KIND_DPLUS :
                                                                  sct_pkg::KIND_DEQ;
                                b_start = pstart_reg;
                                b_len   = POS_BITS'(2);
                                mode_next   = M_IDLE;
                                pstart_next = '0;
                                plen_next   = '0;
                                acc_next    = '0;
                            end
                            else
                                brk = 1'b1;
                        end
                        M_SLASH:
                        begin
                            if (source_byte == sct_pkg::CH_STAR)
                            begin
                                mode_next   = M_COMMENT;
                                pstart_next = '0;
                                plen_next   = '0;
                                acc_next    = '0;
                            end
                            else
                                brk = 1'b1;
                        end
                        default: brk = 1'b1;
                    endcase

                    // byte ends the held token (if any) and may start a new one
                    if (brk)
                    begin
                        a_v         = pend_mode;
                        mode_next   = M_IDLE;
                        pstart_next = '0;
                        plen_next   = '0;
                        acc_next    = '0;
                        if (!is_ws)
                        begin
                            if (is_alpha || is_digit ||
                                source_byte == sct_pkg::CH_MINUS ||
                                source_byte == sct_pkg::CH_PLUS ||
                                source_byte == sct_pkg::CH_EQUAL ||
                                source_byte == sct_pkg::CH_SLASH)
                            begin
                                pstart_next = pos_reg;
                                plen_next   = POS_BITS'(1);
                                if (is_alpha)
                                    mode_next = M_WORD;
                                else if (is_digit)
                                begin
                                    mode_next = M_NUM;
                                    acc_next  = VB'(source_byte - sct_pkg::CH_ZERO);
                                end
                                else if (source_byte == sct_pkg::CH_MINUS)
                                    mode_next = M_MINUS;
                                else if (source_byte == sct_pkg::CH_PLUS)
                                    mode_next = M_PLUS;
                                else if (source_byte == sct_pkg::CH_EQUAL)
                                    mode_next = M_EQ;
                                else
                                    mode_next = M_SLASH;
                            end
                            else
                            begin
                                b_v = 1'b1;
                                if (s_kind != sct_pkg::KIND_WORD)
                                begin
                                    b_kind = s_kind;
                                    b_len  = POS_BITS'(1);
                                end
                                else
                                begin
                                    b_status = sct_pkg::ST_UNKNOWN;
                                    err_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    assign body_a = {f_kind, sct_pkg::ST_OK, pstart_reg, f_len, f_value};
    assign body_b = {b_kind, b_status, b_start, b_len, VB'(0)};

    always_comb
    begin
        if (a_v)
        begin
            wr0        = {body_a, !b_v};
            wr1        = {body_b, 1'b1};
            push.count = b_v ? 2'd2 : 2'd1;
        end
        else
        begin
            wr0        = {body_b, 1'b1};
            wr1        = {body_b, 1'b1};
            push.count = b_v ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            acc_reg    <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            acc_reg    <= acc_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ===== rtl/core/sct_queue.sv =====
// small result queue: two writes and one read per cycle
// uses sct_pkg for depth and status type
`timescale 1ns / 1ps

module sct_queue #(
    parameter int DATA_BITS = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sct_pkg::push_t         push,
    input  logic [DATA_BITS-1:0]   wr0,
    input  logic [DATA_BITS-1:0]   wr1,
    input  logic                   pop,
    output logic [DATA_BITS-1:0]   rd_data,
    output sct_pkg::q_status_t     q_stat
);

    localparam int PB = sct_pkg::QPTR_BITS;
    localparam int LB = sct_pkg::QLEVEL_BITS;

    logic [DATA_BITS-1:0] mem [sct_pkg::QUEUE_DEPTH];
    logic [PB-1:0]        wp_reg, wp_next, rp_reg, rp_next;
    logic [LB-1:0]        level_reg, level_next;
    logic [PB-1:0]        wp_plus;

    assign wp_plus    = wp_reg + 1'b1;
    assign wp_next    = wp_reg + PB'(push.count);
    assign rp_next    = pop ? rp_reg + 1'b1 : rp_reg;
    assign level_next = level_reg + LB'(push.count) - LB'(pop);

    assign rd_data         = mem[rp_reg];
    assign q_stat.room     = (level_reg <= LB'(sct_pkg::QUEUE_DEPTH - 2));
    assign q_stat.nonempty = (level_reg != '0);
    assign q_stat.level    = level_reg;

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wp_reg] <= wr0;
        if (push.count == 2'd2)
            mem[wp_plus] <= wr1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            level_reg <= level_next;
        end
    end

endmodule

// ===== rtl/core/sct_back.sv =====
// output stage: takes results from the queue into the token register
// and holds them while the receiver stalls; uses sct_pkg
`timescale 1ns / 1ps

module sct_back #(
    parameter int POS_BITS = sct_pkg::POSITION_BITS_DEFAULT,
    parameter int RES_BITS = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [RES_BITS-1:0]                  rd_data,
    input  sct_pkg::q_status_t                   q_stat,
    output logic                                 pop,
    output logic                                 token_valid,
    input  logic                                 token_stall,
    output logic [sct_pkg::KIND_BITS-1:0]        token_kind,
    output logic [sct_pkg::STATUS_BITS-1:0]      status,
    output logic [POS_BITS-1:0]                  start_offset,
    output logic [POS_BITS-1:0]                  token_length,
    output logic [sct_pkg::VALUE_BITS-1:0]       integer_value,
    output logic                                 last_of_run
);

    localparam int VB        = sct_pkg::VALUE_BITS;
    localparam int VAL_LO    = 1;
    localparam int LEN_LO    = VAL_LO + VB;
    localparam int START_LO  = LEN_LO + POS_BITS;
    localparam int STATUS_LO = START_LO + POS_BITS;
    localparam int KIND_LO   = STATUS_LO + sct_pkg::STATUS_BITS;

    logic                valid_reg, valid_next;
    logic [RES_BITS-1:0] data_reg;

    assign pop        = q_stat.nonempty && (!valid_reg || !token_stall);
    assign valid_next = pop ? 1'b1 : (valid_reg && token_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= rd_data;
    end

    assign token_valid   = valid_reg;
    assign token_kind    = data_reg[KIND_LO +: sct_pkg::KIND_BITS];
    assign status        = data_reg[STATUS_LO +: sct_pkg::STATUS_BITS];
    assign start_offset  = data_reg[START_LO +: POS_BITS];
    assign token_length  = data_reg[LEN_LO +: POS_BITS];
    assign integer_value = data_reg[VAL_LO +: VB];
    assign last_of_run   = data_reg[0];

endmodule

// ===== rtl/core/source_code_tokenizer.sv =====
// Source code tokenizer, top level: scanner, result queue, output stage.
// Source channel: source_valid / source_stall carry one byte per item, or an
//   end-of-input item (end_of_input high) that flushes the held token and
//   gives the end token with the stream's byte count.
// Token channel: token_valid / token_stall carry one result per item;
//   last_of_run marks the last result caused by one source item.
// An item is taken at any edge with valid high and stall low.
// Throughput: one source item per cycle while source_stall is low; results leave
//   the output one at a time, so an item that gives two results occupies it for both.
// Path: a result enters the queue when its source item is taken, then the token register.
// The scanner stalls the source while the four-entry result queue has fewer
//   than two free entries; a stalled receiver fills the queue and then
//   stalls the source, with nothing lost.
// After any error result the block takes items and gives nothing until reset.
// Reset clears the scanner to the start of a stream and empties the queue.
// Depends on sct_pkg, sct_front, sct_queue, sct_back and the defines header.
`timescale 1ns / 1ps
`include "source_code_tokenizer_defines.svh"

module source_code_tokenizer #(
    parameter int POSITION_BITS = sct_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                source_valid,
    output logic                                source_stall,
    input  logic [7:0]                          source_byte,
    input  logic                                end_of_input,
    output logic                                token_valid,
    input  logic                                token_stall,
    output logic [sct_pkg::KIND_BITS-1:0]       token_kind,
    output logic [sct_pkg::STATUS_BITS-1:0]     status,
    output logic [POSITION_BITS-1:0]            start_offset,
    output logic [POSITION_BITS-1:0]            token_length,
    output logic [sct_pkg::VALUE_BITS-1:0]      integer_value,
    output logic                                last_of_run
);

    localparam int RES_BITS = sct_pkg::KIND_BITS + sct_pkg::STATUS_BITS +
                              2 * POSITION_BITS + sct_pkg::VALUE_BITS + 1;

    sct_pkg::push_t     push;
    sct_pkg::q_status_t q_stat;
    logic [RES_BITS-1:0] wr0, wr1, rd_data;
    logic                pop;

    assign source_stall = !q_stat.room;

    sct_front #(
        .POS_BITS (POSITION_BITS),
        .RES_BITS (RES_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_valid (source_valid),
        .source_byte  (source_byte),
        .end_of_input (end_of_input),
        .q_stat       (q_stat),
        .push         (push),
        .wr0          (wr0),
        .wr1          (wr1)
    );

    sct_queue #(
        .DATA_BITS (RES_BITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr0     (wr0),
        .wr1     (wr1),
        .pop     (pop),
        .rd_data (rd_data),
        .q_stat  (q_stat)
    );

    sct_back #(
        .POS_BITS (POSITION_BITS),
        .RES_BITS (RES_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_data       (rd_data),
        .q_stat        (q_stat),
        .pop           (pop),
        .token_valid   (token_valid),
        .token_stall   (token_stall),
        .token_kind    (token_kind),
        .status        (status),
        .start_offset  (start_offset),
        .token_length  (token_length),
        .integer_value (integer_value),
        .last_of_run   (last_of_run)
    );

    // queue never overfills
    `SCT_ASSERT_IMP(a_queue_level, clk, rst_n, 1'b1, q_stat.level <= sct_pkg::QUEUE_DEPTH)
    // an error result is always an end-kind result with no length or value
    `SCT_ASSERT_IMP(a_error_shape, clk, rst_n, token_valid && status != sct_pkg::ST_OK, token_kind == sct_pkg::KIND_END && token_length == '0 && integer_value == '0)
    // only integer tokens carry a value
    `SCT_ASSERT_IMP(a_value_int_only, clk, rst_n, token_valid && token_kind != sct_pkg::KIND_INT, integer_value == '0)
    // a waiting result reaches an empty output register in the next cycle
    `SCT_ASSERT_NXT(a_output_fill, clk, rst_n, q_stat.nonempty && !token_valid, token_valid)

endmodule
